// ----- rtl/i64alu_pkg.sv -----
// Package: command codes and shared constants for the int64 ALU.
`default_nettype none
package i64alu_pkg;
	typedef enum logic [2:0] {
		CMD_ADD    = 3'd0,
		CMD_SUB    = 3'd1,
		CMD_CMP    = 3'd2,
		CMD_SIGN   = 3'd3,
		CMD_TO_I32 = 3'd4,
		CMD_TO_U32 = 3'd5,
		CMD_TO_DBL = 3'd6,
		CMD_FR_DBL = 3'd7
	} cmd_t;

	localparam logic [63:0] SIGN64    = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX_I64   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MAX_I32   = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] MIN_I32   = 64'hFFFF_FFFF_8000_0000;
	localparam logic [63:0] MAX_U32   = 64'h0000_0000_FFFF_FFFF;
	localparam logic [10:0] EXP_BIAS  = 11'd1023;
	localparam logic [10:0] EXP_MAX   = 11'h7FF;
endpackage
`default_nettype wire

// ----- rtl/i64alu_conv.sv -----
// Conversion unit: integer to double (round to nearest even) and double to integer.
`default_nettype none
module i64alu_conv (
	input  wire logic        to_dbl,
	input  wire logic        is_signed,
	input  wire logic [63:0] a,
	output logic      [63:0] result,
	output logic             in_range
);
	import i64alu_pkg::*;

	// int -> double
	logic        neg;
	logic [63:0] mag;
	logic [5:0]  p;
	logic [63:0] norm;
	logic [52:0] q;
	logic [10:0] rbits;
	logic        rnd;
	logic [53:0] qr;
	logic [10:0] expo;
	logic [63:0] dbl;

	// double -> int
	logic        dneg;
	logic [10:0] e;
	logic [51:0] f;
	logic [63:0] sig;
	logic [63:0] dmag;
	logic        over;
	logic [63:0] fres;
	logic        fok;

	// leading one position, then normalize so the top one sits at bit 63
	always_comb begin
		neg = is_signed & a[63];
		mag = neg ? (64'd0 - a) : a;
		p = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (mag[i]) p = 6'(i);
		end
		norm = mag << (6'd63 - p);
		q = norm[63:11];
		rbits = norm[10:0];
		// guard is rbits[10]; sticky is the rest
		rnd = rbits[10] & ((|rbits[9:0]) | q[0]);
		qr = {1'b0, q} + {53'd0, rnd};
		expo = 11'(p) + EXP_BIAS;
		if (qr[53]) begin
			expo = expo + 11'd1;
		end
		dbl = (mag == 64'd0) ? 64'd0 : {neg, expo, qr[53] ? qr[52:1] : qr[51:0]};
	end

	// truncating conversion with saturation
	always_comb begin
		dneg = a[63];
		e = a[62:52];
		f = a[51:0];
		sig = {11'd0, 1'b1, f};
		dmag = 64'd0;
		over = 1'b0;
		if (e >= EXP_BIAS) begin
			if (e < 11'd1075) dmag = sig >> (11'd1075 - e);
			else if (e <= 11'd1086) dmag = sig << (e - 11'd1075);
			else over = 1'b1;
		end
		fok = 1'b1;
		if (e == EXP_MAX && f != 52'd0) begin
			fok = 1'b0;
			fres = 64'd0;
		end else if (is_signed) begin
			if (!dneg) begin
				if (over || dmag > MAX_I64) begin
					fok = 1'b0;
					fres = MAX_I64;
				end else fres = dmag;
			end else if (over || dmag > SIGN64) begin
				fok = 1'b0;
				fres = SIGN64;
			end else fres = 64'd0 - dmag;
		end else if (dneg) begin
			fres = 64'd0;
			if (over || dmag != 64'd0) fok = 1'b0;
		end else if (over) begin
			fok = 1'b0;
			fres = ALL_ONES;
		end else fres = dmag;
	end

	assign result   = to_dbl ? dbl : fres;
	assign in_range = to_dbl ? 1'b1 : fok;
endmodule
`default_nettype wire

// ----- rtl/int64_alu_with_double_conversion_unit.sv -----
// Top level: int64 ALU with double conversion, input register and result register.
//
// channel | direction | handshake             | payload
// in      | sink      | in_valid / in_stall   | cmd, is_signed, operand_a, operand_b
// out     | source    | out_valid / out_stall | result, in_range
//
// One beat per cycle sustained while out_stall is low.
// Work is one pass of logic between the input register (_s1) and result register (_s2).
// Reset clears both valid flags; payload registers are not reset.
// An out stall holds the result and propagates back to in_stall only when both stages are full.
`default_nettype none
module int64_alu_with_double_conversion_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  cmd,
	input  wire logic        is_signed,
	input  wire logic [63:0] operand_a,
	input  wire logic [63:0] operand_b,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [63:0] result,
	output logic             in_range
);
	import i64alu_pkg::*;

	logic        vld_s1, vld_s2;
	cmd_t        cmd_s1;
	logic        sgn_s1;
	logic [63:0] a_s1, b_s1;
	logic [63:0] res_s2;
	logic        ok_s2;
	logic        adv_s2, adv_s1;

	logic [63:0] r;
	logic        ok;
	logic [63:0] ka, kb;
	logic [63:0] cres;
	logic        cok;

	assign adv_s2   = vld_s1 & (~vld_s2 | ~out_stall);
	assign in_stall = vld_s1 & ~adv_s2;
	assign adv_s1   = in_valid & ~in_stall;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= 1'b1;
			else if (adv_s2) vld_s1 <= 1'b0;
			if (adv_s2) vld_s2 <= 1'b1;
			else if (~out_stall) vld_s2 <= 1'b0;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cmd_s1 <= cmd_t'(cmd);
			sgn_s1 <= is_signed;
			a_s1   <= operand_a;
			b_s1   <= operand_b;
		end
	end

	i64alu_conv u_conv (
		.to_dbl   (cmd_s1 == CMD_TO_DBL),
		.is_signed(sgn_s1),
		.a        (a_s1),
		.result   (cres),
		.in_range (cok)
	);

	// command decode
	always_comb begin
		ka = sgn_s1 ? (a_s1 ^ SIGN64) : a_s1;
		kb = sgn_s1 ? (b_s1 ^ SIGN64) : b_s1;
		r  = 64'd0;
		ok = 1'b1;
		case (cmd_s1)
			CMD_ADD: r = a_s1 + b_s1;
			CMD_SUB: r = a_s1 - b_s1;
			CMD_CMP: r = (ka > kb) ? 64'd1 : (ka < kb) ? ALL_ONES : 64'd0;
			CMD_SIGN: begin
				if (a_s1 == 64'd0) r = 64'd0;
				else if (sgn_s1 && a_s1[63]) r = ALL_ONES;
				else r = 64'd1;
			end
			CMD_TO_I32: begin
				if (sgn_s1) begin
					if (a_s1[63:31] == 33'd0 || a_s1[63:31] == {33{1'b1}}) r = a_s1;
					else begin
						ok = 1'b0;
						r  = a_s1[63] ? MIN_I32 : MAX_I32;
					end
				end else if (a_s1 <= MAX_I32) r = a_s1;
				else begin
					ok = 1'b0;
					r  = MAX_I32;
				end
			end
			CMD_TO_U32: begin
				if (a_s1[63:32] == 32'd0) r = a_s1;
				else begin
					ok = 1'b0;
					r  = (sgn_s1 && a_s1[63]) ? 64'd0 : MAX_U32;
				end
			end
			CMD_TO_DBL, CMD_FR_DBL: begin
				r  = cres;
				ok = cok;
			end
			default: begin
				r  = 64'd0;
				ok = 1'b1;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= r;
			ok_s2  <= ok;
		end
	end

	assign out_valid = vld_s2;
	assign result    = res_s2;
	assign in_range  = ok_s2;
endmodule
`default_nettype wire
